FILE: rtl/periodic_interval_timer_array_assert.svh
// Assertion macros shared by the timer array RTL.
`ifndef PERIODIC_INTERVAL_TIMER_ARRAY_ASSERT_SVH
`define PERIODIC_INTERVAL_TIMER_ARRAY_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PITA_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PITA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/pita_pkg.sv
// Package with the sizes, codes and helpers of the periodic interval timer array.
`timescale 1ns / 1ps
`default_nettype none

package pita_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int CNT_W      = 24;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TIDX_W     = 16;
    localparam int IVL_W      = 24;
    localparam int EXT_W      = 33;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] interval;
        logic [CNT_W-1:0] count;
    } entry_t;

    // Clamp a start interval to the counter range; zero becomes one.
    function automatic logic [CNT_W-1:0] load_value(input logic [IVL_W-1:0] ivl);
        logic [EXT_W-1:0] ext;
        logic [CNT_W-1:0] v;
        ext = EXT_W'(ivl);
        if (ext > EXT_W'(CNT_MAX))
            v = CNT_MAX;
        else
            v = CNT_W'(ext);
        if (v == '0)
            v = CNT_W'(1);
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/periodic_interval_timer_array.sv
// Top level of the periodic interval timer array with its timer memory.
//
//  channel   handshake               payload
//  command   start in, busy out      cmd, timer_index, interval_ticks
//  result    done out (one cycle)    expired
//
// Tick, start and stop keep busy high through the execute state; done follows.
// A query with no pending ticks does the same; otherwise it walks the timer memory,
// one entry per cycle through its single read port, then passes the finish state.
// The result strobe comes in the same cycle that busy drops; the next command may
// transfer in that same cycle. The result cannot be stalled.
// Reset clears all control state but the captured command payload; the memory needs
// no clearing because a per-timer running bit guards every read.
`timescale 1ns / 1ps
`default_nettype none

`include "periodic_interval_timer_array_assert.svh"

module periodic_interval_timer_array (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  cmd,
    input  wire logic [pita_pkg::TIDX_W-1:0] timer_index,
    input  wire logic [pita_pkg::IVL_W-1:0]  interval_ticks,
    output logic                             done,
    output logic                             expired
);
    import pita_pkg::*;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       pending_reg, pending_next;
    logic [CNT_W-1:0]       delta_reg, delta_next;
    logic [NUM_TIMERS-1:0]  running_reg, running_next;
    logic [NUM_TIMERS-1:0]  flag_reg, flag_next;
    logic                   done_reg, done_next;
    logic                   expired_reg, expired_next;

    cmd_t                   cmd_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   idx_ok_reg;
    logic [IVL_W-1:0]       ivl_reg;

    entry_t                 mem [NUM_TIMERS];
    entry_t                 rdata_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;

    logic                   accept;

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign expired = expired_reg;

    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        pending_next = pending_reg;
        delta_next   = delta_reg;
        running_next = running_reg;
        flag_next    = flag_reg;
        done_next    = 1'b0;
        expired_next = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = '{interval: load_value(ivl_reg), count: load_value(ivl_reg)};
        mem_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (pending_reg != CNT_MAX)
                            pending_next = pending_reg + CNT_W'(1);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    CMD_START:
                    begin
                        if (idx_ok_reg)
                        begin
                            mem_we                = 1'b1;
                            running_next[idx_reg] = 1'b1;
                            flag_next[idx_reg]    = 1'b0;
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    CMD_STOP:
                    begin
                        if (idx_ok_reg)
                            running_next[idx_reg] = 1'b0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    CMD_QUERY:
                    begin
                        if (pending_reg == '0)
                        begin
                            if (idx_ok_reg)
                            begin
                                expired_next       = flag_reg[idx_reg];
                                flag_next[idx_reg] = 1'b0;
                            end
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // Entry zero is read now and arrives in the first sweep cycle.
                            delta_next   = pending_reg;
                            pending_next = '0;
                            ptr_next     = '0;
                            mem_raddr    = '0;
                            state_next   = S_SWEEP;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SWEEP:
            begin
                // The write goes to the current entry and the read to the next one, except at the
                // last entry, where both ports address the same entry.
                mem_waddr = ptr_reg;
                if (running_reg[ptr_reg])
                begin
                    mem_we = 1'b1;
                    if (rdata_reg.count <= delta_reg)
                    begin
                        mem_wdata          = '{interval: rdata_reg.interval,
                                               count: rdata_reg.interval};
                        flag_next[ptr_reg] = 1'b1;
                    end
                    else
                    begin
                        mem_wdata = '{interval: rdata_reg.interval,
                                      count: rdata_reg.count - delta_reg};
                    end
                end
                if (ptr_reg == LAST_IDX)
                begin
                    mem_raddr  = ptr_reg;
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_raddr = ptr_reg + IDX_W'(1);
                    ptr_next  = ptr_reg + IDX_W'(1);
                end
            end
            S_FINISH:
            begin
                if (idx_ok_reg)
                begin
                    expired_next       = flag_reg[idx_reg];
                    flag_next[idx_reg] = 1'b0;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ptr_reg     <= '0;
            pending_reg <= '0;
            delta_reg   <= '0;
            running_reg <= '0;
            flag_reg    <= '0;
            done_reg    <= 1'b0;
            expired_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            pending_reg <= pending_next;
            delta_reg   <= delta_next;
            running_reg <= running_next;
            flag_reg    <= flag_next;
            done_reg    <= done_next;
            expired_reg <= expired_next;
        end
    end

    // Command payload captured on a transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(cmd);
            idx_reg    <= timer_index[IDX_W-1:0];
            idx_ok_reg <= (timer_index < TIDX_W'(NUM_TIMERS));
            ivl_reg    <= interval_ticks;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    `PITA_ASSERT_NEXT(a_accept_busy, accept, busy, "Transfer did not make the block busy")
    `PITA_ASSERT_SAME(a_expired_strobe, expired_reg, done_reg, "Expiry shown without a strobe")
    `PITA_ASSERT_NEXT(a_single_strobe, done_reg, !done_reg, "Result strobe lasted two cycles")
    `PITA_ASSERT_NEXT(a_sweep_end, (state_reg == S_SWEEP) && (ptr_reg == LAST_IDX),
        state_reg == S_FINISH, "Sweep did not finish after the last timer")
    `PITA_ASSERT_SAME(a_sweep_pending, state_reg == S_SWEEP, pending_reg == '0,
        "Pending ticks not cleared during a sweep")

endmodule

`default_nettype wire
